// ----- rtl/core/mecd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mecd_pkg
// Types and constants of the midi event command decoder.
// ----------------------------------------------------------------------------
package mecd_pkg;

   localparam int DELTA_W = 28;
   localparam int PARAM_W = 17;

   localparam logic [7:0] STATUS_META   = 8'hFF;
   localparam logic [3:0] STATUS_NOTEON = 4'h9;
   localparam logic [7:0] META_NAME     = 8'h03;
   localparam logic [7:0] META_EOT      = 8'h2F;
   localparam logic [7:0] KEY_PULSE_FREQ = 8'h20;
   localparam logic [7:0] KEY_LOW_HOLD   = 8'h28;

   // key groups, key[7:3]
   localparam logic [4:0] GRP_BASE_FREQ = 5'h00;
   localparam logic [4:0] GRP_SLEWRATE  = 5'h01;
   localparam logic [4:0] GRP_MISC      = 5'h02;
   localparam logic [4:0] GRP_MOD_FREQ  = 5'h03;
   localparam logic [4:0] GRP_PULSE     = 5'h04;
   localparam logic [4:0] GRP_HOLD      = 5'h05;

   // keys inside the misc group, key[2:0]
   localparam logic [2:0] SUB_AMPL0     = 3'd0;
   localparam logic [2:0] SUB_AMPL1     = 3'd1;
   localparam logic [2:0] SUB_ABORT     = 3'd2;
   localparam logic [2:0] SUB_NOP       = 3'd3;
   localparam logic [2:0] SUB_MOD_DEPTH = 3'd4;
   localparam logic [2:0] SUB_PLS_DEPTH = 3'd5;
   localparam logic [2:0] SUB_PHASE     = 3'd6;

   // phase shift selector, value[6:4]
   localparam logic [2:0] PHS_BASE  = 3'd1;
   localparam logic [2:0] PHS_PULSE = 3'd2;
   localparam logic [2:0] PHS_AMOD  = 3'd3;

   typedef enum logic [2:0] {
      PH_START = 3'd0,
      PH_TIME  = 3'd1,
      PH_CODE  = 3'd2,
      PH_KEY   = 3'd3,
      PH_VALUE = 3'd4,
      PH_NAME  = 3'd5
   } phase_type;

   typedef enum logic [3:0] {
      ACT_NONE        = 4'd0,
      ACT_NOP         = 4'd1,
      ACT_BASE_FREQ   = 4'd2,
      ACT_SLEWRATE    = 4'd3,
      ACT_AMPL        = 4'd4,
      ACT_MOD_DEPTH   = 4'd5,
      ACT_PLS_DEPTH   = 4'd6,
      ACT_BASE_PHASE  = 4'd7,
      ACT_PLS_PHASE   = 4'd8,
      ACT_AMOD_PHASE  = 4'd9,
      ACT_MOD_FREQ    = 4'd10,
      ACT_PLS_FREQ    = 4'd11,
      ACT_HIGH_HOLD   = 4'd12,
      ACT_LOW_HOLD    = 4'd13,
      ACT_TRACK_NAME  = 4'd14
   } action_type;

   typedef struct packed {
      action_type           kind;
      logic [PARAM_W-1:0]   param;
      logic                 abort;
   } command_type;

endpackage

// ----- rtl/core/midi_event_command_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_event_command_decoder
// Parses a MIDI track byte stream into stimulator commands.
// ----------------------------------------------------------------------------
// Usage:
//   req_* takes one track byte per transfer. Each event is an optional
//   variable-length delta time (when csr_wdata last written was 1, the reset
//   value), a status, a key and a value byte; meta name events also consume
//   their name string. rsp_* delivers one result per completed event.
//   An event's last byte lands in the input register at its transfer, and
//   the result register loads its result from the decode stage when the
//   result register is free.
//   Throughput: one byte per cycle unless the receiver stalls, set by the
//   single decode stage between the input register and the result register;
//   bytes that complete no event keep flowing while a result waits on rsp_tready.
//   When the receiver stalls, a waiting result holds the decode stage and
//   req_tready drops once the input register also holds an event-completing
//   byte.
//   After meta end of track (rsp_tlast) or an abort command, bytes are still
//   taken but ignored until reset.
//   Reset (synchronous, active high) returns the parser to the start of an
//   event, clears both pipeline stages and enables delta times.
// ----------------------------------------------------------------------------
module midi_event_command_decoder
   import mecd_pkg::*;
#(
   parameter int TIME_BITS = 28
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_wdata,     // timestamp_enabled
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,     // stream_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,     // channel[3:0], param_value[20:4],
                                      // delta_time[48:21], abort_seen[49], zero
   output logic [3:0]  rsp_tuser,     // action_kind
   output logic        rsp_tlast      // end_of_track
);

   // configuration
   logic ts_enable_ff;

   // input register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;

   // parser state
   phase_type            phase_ff, phase_in;
   logic [TIME_BITS-1:0] acc_ff, acc_in;
   logic [7:0]           status_ff, status_in;
   logic [7:0]           key_ff, key_in;
   logic [7:0]           remain_ff, remain_in;
   logic                 finished_ff, finished_in;

   // result register
   logic               out_valid_ff;
   action_type         out_kind_ff;
   logic [3:0]         out_chan_ff;
   logic [PARAM_W-1:0] out_param_ff;
   logic [DELTA_W-1:0] out_delta_ff;
   logic               out_eot_ff;
   logic               out_abort_ff;

   // decode stage
   phase_type            eff_phase;
   logic [TIME_BITS-1:0] acc_cur;
   logic [TIME_BITS-1:0] acc_sum;
   logic                 emit;
   logic                 emit_eot;
   command_type          cmd;
   command_type          dec_cmd;
   logic                 out_free;
   logic                 stage_go;
   logic                 out_load;

   function automatic logic [PARAM_W-1:0] shift_val(input logic [7:0] val,
                                                    input logic [3:0] sh);
      return PARAM_W'(val) << sh;
   endfunction

   function automatic command_type decode_cmd(input logic [7:0] key,
                                              input logic [7:0] val);
      command_type d;
      d = '{kind: ACT_NONE, param: '0, abort: 1'b0};
      unique case (key[7:3])
         GRP_BASE_FREQ: begin
            d.kind  = ACT_BASE_FREQ;
            d.param = shift_val(val, 4'(key[2:0]) + 4'd1);
         end
         GRP_SLEWRATE: begin
            d.kind  = ACT_SLEWRATE;
            d.param = shift_val(val, 4'(key[2:0]));
         end
         GRP_MISC: begin
            unique case (key[2:0]) inside
               SUB_AMPL0, SUB_AMPL1: begin
                  d.kind  = ACT_AMPL;
                  d.param = shift_val(val, 4'(key[0]));
               end
               SUB_ABORT: d.abort = 1'b1;
               SUB_NOP:   d.kind  = ACT_NOP;
               SUB_MOD_DEPTH: begin
                  d.kind  = ACT_MOD_DEPTH;
                  d.param = shift_val(val, 4'd1);
               end
               SUB_PLS_DEPTH: begin
                  d.kind  = ACT_PLS_DEPTH;
                  d.param = shift_val(val, 4'd1);
               end
               SUB_PHASE: begin
                  unique case (val[6:4])
                     PHS_BASE:  d.kind = ACT_BASE_PHASE;
                     PHS_PULSE: d.kind = ACT_PLS_PHASE;
                     PHS_AMOD:  d.kind = ACT_AMOD_PHASE;
                     default:   d.kind = ACT_NONE;
                  endcase
                  d.param = PARAM_W'(val[3:0]);
               end
               default: d.kind = ACT_NONE;
            endcase
         end
         GRP_MOD_FREQ: begin
            d.kind  = ACT_MOD_FREQ;
            d.param = shift_val(val, 4'(key[2:0]));
         end
         GRP_PULSE: begin
            if (key == KEY_PULSE_FREQ) begin
               d.kind  = ACT_PLS_FREQ;
               d.param = shift_val(val, 4'(key[1:0]));
            end else begin
               d.kind  = ACT_HIGH_HOLD;
               d.param = shift_val(val, 4'd6 + 4'(key[1:0]));
            end
         end
         GRP_HOLD: begin
            // the other keys of this group act as nop but keep the shift
            d.kind  = (key == KEY_LOW_HOLD) ? ACT_LOW_HOLD : ACT_NOP;
            d.param = shift_val(val, 4'd6 + 4'(key[1:0]));
         end
         default: d.kind = ACT_NONE;
      endcase
      return d;
   endfunction

   assign dec_cmd = decode_cmd(key_ff, in_byte_ff);
   assign acc_sum = acc_cur + TIME_BITS'(in_byte_ff[6:0]);

   always_comb begin
      eff_phase   = phase_ff;
      acc_cur     = acc_ff;
      if (phase_ff == PH_START) begin
         acc_cur   = '0;
         eff_phase = ts_enable_ff ? PH_TIME : PH_CODE;
      end
      phase_in    = eff_phase;
      acc_in      = acc_cur;
      status_in   = status_ff;
      key_in      = key_ff;
      remain_in   = remain_ff;
      finished_in = finished_ff;
      emit        = 1'b0;
      emit_eot    = 1'b0;
      cmd         = '{kind: ACT_NONE, param: '0, abort: 1'b0};
      unique case (eff_phase)
         PH_TIME: begin
            if (in_byte_ff[7]) begin
               acc_in = {acc_sum[TIME_BITS-8:0], 7'd0};
            end else begin
               acc_in   = acc_sum;
               phase_in = PH_CODE;
            end
         end
         PH_CODE: begin
            status_in = in_byte_ff;
            phase_in  = PH_KEY;
         end
         PH_KEY: begin
            key_in   = in_byte_ff;
            phase_in = PH_VALUE;
         end
         PH_VALUE: begin
            if (status_ff == STATUS_META) begin
               if (key_ff == META_NAME) begin
                  if (in_byte_ff != 8'd0) begin
                     remain_in = in_byte_ff - 8'd1;
                     phase_in  = PH_NAME;
                  end else begin
                     emit     = 1'b1;
                     cmd.kind = ACT_TRACK_NAME;
                  end
               end else if (key_ff == META_EOT) begin
                  emit        = 1'b1;
                  emit_eot    = 1'b1;
                  finished_in = 1'b1;
               end else begin
                  // unknown meta key ends the event with no action
                  emit = 1'b1;
               end
            end else begin
               emit = 1'b1;
               if (status_ff[7:4] == STATUS_NOTEON) begin
                  cmd = dec_cmd;
               end
               if (cmd.abort) begin
                  finished_in = 1'b1;
               end
            end
         end
         PH_NAME: begin
            if (remain_ff != 8'd0) begin
               remain_in = remain_ff - 8'd1;
            end else begin
               emit     = 1'b1;
               cmd.kind = ACT_TRACK_NAME;
            end
         end
         default: phase_in = PH_START;
      endcase
      if (emit) begin
         phase_in = PH_START;
      end
   end

   // the decode stage waits only when it has a result and a result waits on rsp_tready
   assign out_free   = !out_valid_ff || rsp_tready;
   assign stage_go   = in_valid_ff && (!emit || finished_ff || out_free);
   assign out_load   = stage_go && emit && !finished_ff;
   assign req_tready = !in_valid_ff || stage_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         ts_enable_ff <= 1'b1;
      end else if (csr_we) begin
         ts_enable_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_START;
         acc_ff      <= '0;
         status_ff   <= '0;
         key_ff      <= '0;
         remain_ff   <= '0;
         finished_ff <= 1'b0;
      end else if (stage_go && !finished_ff) begin
         phase_ff    <= phase_in;
         acc_ff      <= acc_in;
         status_ff   <= status_in;
         key_ff      <= key_in;
         remain_ff   <= remain_in;
         finished_ff <= finished_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_kind_ff  <= cmd.kind;
         out_chan_ff  <= status_ff[3:0];
         out_param_ff <= cmd.param;
         out_delta_ff <= DELTA_W'(acc_cur);
         out_eot_ff   <= emit_eot;
         out_abort_ff <= cmd.abort;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_eot_ff;
   assign rsp_tdata  = {6'd0, out_abort_ff, out_delta_ff, out_param_ff, out_chan_ff};

   // once the track is over the parser state stays frozen
   a_finished_sticky: assert property (@(posedge clock) disable iff (reset)
      finished_ff |=> finished_ff)
      else $error("track finished flag cleared without reset");

   a_finish_follows: assert property (@(posedge clock) disable iff (reset)
      out_load && (emit_eot || cmd.abort) |=> finished_ff && out_valid_ff)
      else $error("end of track or abort did not stop the parser");

   a_no_result_after_end: assert property (@(posedge clock) disable iff (reset)
      finished_ff |-> !out_load)
      else $error("result produced after end of track");

   a_name_only_meta: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_NAME |-> status_ff == STATUS_META && key_ff == META_NAME)
      else $error("name string skipped outside a meta name event");

   a_flags_no_action: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_eot_ff || out_abort_ff) |->
         out_kind_ff == ACT_NONE && !(out_eot_ff && out_abort_ff))
      else $error("end of track or abort carries an action");

endmodule

// ----- tb/midi_event_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_event_checker
// Follows every track byte that enters the decoder, works out the command
// result of each completed event and compares it field by field with each
// result that leaves on rsp_*.
// ----------------------------------------------------------------------------
module midi_event_checker
   import mecd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_wdata,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [55:0] rsp_tdata,
   input  logic [3:0]  rsp_tuser,
   input  logic        rsp_tlast,
   output int          mismatch_count,
   output int          pending_count,
   output int          result_count
);

   typedef struct packed {
      action_type          kind;
      logic [3:0]          channel;
      logic [PARAM_W-1:0]  param;
      logic [DELTA_W-1:0]  delta;
      logic                end_of_track;
      logic                abort;
   } decoded_event_type;

   decoded_event_type expected_events [$];

   logic               timestamps_on;
   phase_type          parse_ph;
   logic [DELTA_W-1:0] delta_acc;
   logic [7:0]         status_q;
   logic [7:0]         key_q;
   logic [7:0]         name_left;
   logic               stream_closed;

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
      result_count   = 0;
   end

   function automatic logic [PARAM_W-1:0] scaled_value(input logic [7:0] value,
                                                       input logic [7:0] key,
                                                       input int exp_bits,
                                                       input int base_shift);
      logic [7:0]  mask;
      logic [31:0] wide;
      mask = 8'((1 << exp_bits) - 1);
      wide = {24'd0, value} << (base_shift + int'(key & mask));
      return wide[PARAM_W-1:0];
   endfunction

   function automatic decoded_event_type decode_note(input logic [7:0] status,
                                                     input logic [7:0] key,
                                                     input logic [7:0] value);
      decoded_event_type cmd;
      cmd = '0;
      if (status[7:4] == STATUS_NOTEON) begin
         case (key[7:3])
            GRP_BASE_FREQ: begin
               cmd.kind  = ACT_BASE_FREQ;
               cmd.param = scaled_value(value, key, 3, 1);
            end
            GRP_SLEWRATE: begin
               cmd.kind  = ACT_SLEWRATE;
               cmd.param = scaled_value(value, key, 3, 0);
            end
            GRP_MISC: begin
               case (key[2:0])
                  SUB_AMPL0, SUB_AMPL1: begin
                     cmd.kind  = ACT_AMPL;
                     cmd.param = scaled_value(value, key, 1, 0);
                  end
                  SUB_ABORT: cmd.abort = 1'b1;
                  SUB_NOP: cmd.kind = ACT_NOP;
                  SUB_MOD_DEPTH: begin
                     cmd.kind  = ACT_MOD_DEPTH;
                     cmd.param = scaled_value(value, key, 0, 1);
                  end
                  SUB_PLS_DEPTH: begin
                     cmd.kind  = ACT_PLS_DEPTH;
                     cmd.param = scaled_value(value, key, 0, 1);
                  end
                  SUB_PHASE: begin
                     // the selector ignores value bit 7, the nibble rides along
                     case (value[6:4])
                        PHS_BASE:  cmd.kind = ACT_BASE_PHASE;
                        PHS_PULSE: cmd.kind = ACT_PLS_PHASE;
                        PHS_AMOD:  cmd.kind = ACT_AMOD_PHASE;
                        default:   cmd.kind = ACT_NONE;
                     endcase
                     cmd.param = PARAM_W'(value[3:0]);
                  end
                  default: cmd.kind = ACT_NONE;
               endcase
            end
            GRP_MOD_FREQ: begin
               cmd.kind  = ACT_MOD_FREQ;
               cmd.param = scaled_value(value, key, 3, 0);
            end
            GRP_PULSE: begin
               if (key == KEY_PULSE_FREQ) begin
                  cmd.kind  = ACT_PLS_FREQ;
                  cmd.param = scaled_value(value, key, 2, 0);
               end else begin
                  cmd.kind  = ACT_HIGH_HOLD;
                  cmd.param = scaled_value(value, key, 2, 6);
               end
            end
            GRP_HOLD: begin
               // the other keys of this group are nops that still carry a value
               cmd.kind  = (key == KEY_LOW_HOLD) ? ACT_LOW_HOLD : ACT_NOP;
               cmd.param = scaled_value(value, key, 2, 6);
            end
            default: cmd.kind = ACT_NONE;
         endcase
      end
      return cmd;
   endfunction

   task automatic queue_result(input decoded_event_type cmd);
      decoded_event_type full;
      full         = cmd;
      full.channel = status_q[3:0];
      full.delta   = delta_acc;
      expected_events.insert(expected_events.size(), full);
      parse_ph = PH_START;
   endtask

   task automatic take_byte(input logic [7:0] b);
      decoded_event_type cmd;
      cmd = '0;
      if (!stream_closed) begin
         if (parse_ph == PH_START) begin
            delta_acc = '0;
            parse_ph  = timestamps_on ? PH_TIME : PH_CODE;
         end
         case (parse_ph)
            PH_TIME: begin
               if (b[7]) begin
                  delta_acc = (delta_acc + DELTA_W'(b[6:0])) << 7;
               end else begin
                  delta_acc = delta_acc + DELTA_W'(b);
                  parse_ph  = PH_CODE;
               end
            end
            PH_CODE: begin
               status_q = b;
               parse_ph = PH_KEY;
            end
            PH_KEY: begin
               key_q    = b;
               parse_ph = PH_VALUE;
            end
            PH_VALUE: begin
               if (status_q == STATUS_META) begin
                  if (key_q == META_NAME && b != 8'd0) begin
                     name_left = b - 8'd1;
                     parse_ph  = PH_NAME;
                  end else begin
                     if (key_q == META_NAME) begin
                        cmd.kind = ACT_TRACK_NAME;
                     end else if (key_q == META_EOT) begin
                        cmd.end_of_track = 1'b1;
                        stream_closed    = 1'b1;
                     end
                     queue_result(cmd);
                  end
               end else begin
                  cmd = decode_note(status_q, key_q, b);
                  if (cmd.abort) begin
                     stream_closed = 1'b1;
                  end
                  queue_result(cmd);
               end
            end
            PH_NAME: begin
               if (name_left != 8'd0) begin
                  name_left = name_left - 8'd1;
               end else begin
                  cmd.kind = ACT_TRACK_NAME;
                  queue_result(cmd);
               end
            end
            default: parse_ph = PH_START;
         endcase
      end
   endtask

   task automatic flag_mismatch(input string msg);
      $display("mismatch at %0t ns: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic check_result();
      decoded_event_type want;
      result_count++;
      if (expected_events.size() == 0) begin
         flag_mismatch($sformatf("result %0d (action %0d) with no event pending",
                                 result_count, rsp_tuser));
      end else begin
         want = expected_events.pop_front();
         if (rsp_tuser != want.kind)
            flag_mismatch($sformatf("result %0d: action_kind %0d, expected %0d",
                                    result_count, rsp_tuser, want.kind));
         if (rsp_tdata[3:0] != want.channel)
            flag_mismatch($sformatf("result %0d: channel %0d, expected %0d",
                                    result_count, rsp_tdata[3:0], want.channel));
         if (rsp_tdata[20:4] != want.param)
            flag_mismatch($sformatf("result %0d: param_value %0d, expected %0d",
                                    result_count, rsp_tdata[20:4], want.param));
         if (rsp_tdata[48:21] != want.delta)
            flag_mismatch($sformatf("result %0d: delta_time %0d, expected %0d",
                                    result_count, rsp_tdata[48:21], want.delta));
         if (rsp_tdata[49] != want.abort)
            flag_mismatch($sformatf("result %0d: abort_seen %0b, expected %0b",
                                    result_count, rsp_tdata[49], want.abort));
         if (rsp_tlast != want.end_of_track)
            flag_mismatch($sformatf("result %0d: end_of_track %0b, expected %0b",
                                    result_count, rsp_tlast, want.end_of_track));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_events.delete();
         timestamps_on = 1'b1;
         parse_ph      = PH_START;
         delta_acc     = '0;
         status_q      = '0;
         key_q         = '0;
         name_left     = '0;
         stream_closed = 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_result();
         end
         if (csr_we) begin
            timestamps_on = csr_wdata;
         end
         if (req_tvalid && req_tready) begin
            take_byte(req_tdata);
         end
      end
      pending_count = expected_events.size();
   end

endmodule

// ----- tb/tb_midi_event_command_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_midi_event_command_decoder
// Feeds MIDI track byte streams into the decoder: a few hand-built events
// first, then random events with and without delta times under several
// traffic patterns, ended by end of track or abort. A checker beside the
// block predicts every result.
// ----------------------------------------------------------------------------
module tb_midi_event_command_decoder
   import mecd_pkg::*;
();

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_CYCLES    = 400;
   localparam int DRAIN_CYCLES   = 6;
   localparam int PHASE_BYTES    = 130;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        csr_we     = 1'b0;
   logic        csr_wdata  = 1'b0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'd0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic [3:0]  rsp_tuser;
   logic        rsp_tlast;

   int   mismatch_count;
   int   pending_count;
   int   result_count;
   int   bytes_sent     = 0;
   int   idle_pct       = 0;
   int   stall_pct      = 0;
   int   quiet_cycles   = 0;
   logic rx_hold        = 1'b0;
   logic ts_mode        = 1'b1;
   logic ended_by_abort = 1'b0;

   // long wrapping delta, a low status byte, an empty name, an unknown meta
   // key, an odd nop key and a phase shift with no valid selector
   logic [7:0] opening_bytes [28] = '{
      8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F, {STATUS_NOTEON, 4'hF}, {GRP_PULSE, 3'd7}, 8'hFF,
      8'h00, 8'h7F, 8'h00, 8'h00,
      8'h00, STATUS_META, META_NAME, 8'h00,
      8'h00, STATUS_META, 8'h51, 8'h80,
      8'h00, {STATUS_NOTEON, 4'hA}, {GRP_HOLD, 3'd5}, 8'h81,
      8'h00, {STATUS_NOTEON, 4'h3}, {GRP_MISC, SUB_PHASE}, 8'hC5
   };

   midi_event_command_decoder DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   midi_event_checker event_check (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .result_count   (result_count)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !rx_hold && ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                  WATCHDOG_LIMIT, pending_count);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_byte(input logic [7:0] b);
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_delta();
      int r;
      int n;
      r = $urandom_range(99);
      n = (r < 50) ? 1 : (r < 80) ? 2 : (r < 92) ? 3 : (r < 97) ? 4 : $urandom_range(5, 6);
      repeat (n - 1) send_byte({1'b1, 7'($urandom)});
      send_byte({1'b0, 7'($urandom)});
   endtask

   task automatic send_event();
      logic [7:0] status;
      logic [7:0] key;
      logic [7:0] value;
      int         r;
      if (ts_mode) begin
         send_delta();
      end
      r      = $urandom_range(99);
      status = 8'($urandom);
      key    = 8'($urandom);
      value  = 8'($urandom);
      if (r < 70) begin
         status = {STATUS_NOTEON, 4'($urandom)};
         if (r < 60) key = 8'($urandom_range(0, 8'h2F));
      end else if (r < 85) begin
         status = STATUS_META;
         if (r < 78) begin
            key   = META_NAME;
            value = 8'($urandom_range(0, 12));
         end
      end
      // the stream must stay open until its planned end
      if ((status == STATUS_META && key == META_EOT) ||
          (status[7:4] == STATUS_NOTEON && key == {GRP_MISC, SUB_ABORT})) begin
         key = key ^ 8'h01;
      end
      send_byte(status);
      send_byte(key);
      send_byte(value);
      if (status == STATUS_META && key == META_NAME) begin
         repeat (value) send_byte(8'($urandom));
      end
   endtask

   task automatic drain_block(input int extra);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_timestamp_mode(input logic enable);
      drain_block(DRAIN_CYCLES);
      csr_we    <= 1'b1;
      csr_wdata <= enable;
      @(posedge clock);
      csr_we    <= 1'b0;
      ts_mode   = enable;
   endtask

   task automatic run_phase(input logic ts, input int idle, input int stall,
                            input bit hold_rx);
      int first;
      write_timestamp_mode(ts);
      idle_pct  = idle;
      stall_pct <= stall;
      if (hold_rx) begin
         fork
            begin
               rx_hold <= 1'b1;
               repeat (HOLD_CYCLES) @(posedge clock);
               rx_hold <= 1'b0;
            end
         join_none
      end
      first = bytes_sent;
      while (bytes_sent - first < PHASE_BYTES) send_event();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      write_timestamp_mode(1'b1);
      foreach (opening_bytes[i]) send_byte(opening_bytes[i]);

      run_phase(1'b1, 0, 0, 1'b0);
      run_phase(1'b0, 58, 0, 1'b0);
      run_phase(1'b1, 0, 58, 1'b0);
      run_phase(1'b0, 24, 24, 1'b0);

      // longest possible name string
      send_byte(STATUS_META);
      send_byte(META_NAME);
      send_byte(8'hFF);
      repeat (255) send_byte(8'($urandom));

      // receiver holds off while bytes keep coming
      run_phase(1'b1, 0, 0, 1'b1);

      ended_by_abort = 1'($urandom_range(1));
      send_delta();
      if (ended_by_abort) begin
         send_byte({STATUS_NOTEON, 4'($urandom)});
         send_byte({GRP_MISC, SUB_ABORT});
      end else begin
         send_byte(STATUS_META);
         send_byte(META_EOT);
      end
      send_byte(8'($urandom));
      // everything after the end must be swallowed
      repeat (8) send_byte(8'($urandom));
      drain_block(20);

      $display("summary: %0d track bytes, %0d results checked, delta times on and off",
               bytes_sent, result_count);
      $display("traffic: back to back, sender gaps, receiver stalls, both, long hold; %s",
               ended_by_abort ? "stream closed by abort" : "stream closed by end of track");
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ----- midi_event_command_decoder.f -----
rtl/core/mecd_pkg.sv
rtl/core/midi_event_command_decoder.sv
tb/midi_event_checker.sv
tb/tb_midi_event_command_decoder.sv
